FILE: rtl/lmfb_pkg.sv
// Shared types and constants for the LED matrix frame buffer updater.
// No dependencies; imported by lmfb_store, led_matrix_frame_buffer_updater, lmfb_checker and testbench.
`timescale 1ns / 1ps

package lmfb_pkg;

   // Default number of chained 8x8 driver chips
   localparam int CHIPS_DEFAULT = 2;
   // Rows per chip, and the last row index
   localparam int ROWS     = 8;
   localparam int LAST_ROW = ROWS - 1;

   // Request codes
   typedef enum logic [1:0] {
      OP_WRITE  = 2'd0,
      OP_TOGGLE = 2'd1,
      OP_READ   = 2'd2,
      OP_CLEAR  = 2'd3
   } req_op_type;

   // Sequencer states
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_FETCH,
      ST_MODIFY,
      ST_CLEAR,
      ST_EMIT
   } seq_state_type;

   // Store control from the sequencer
   typedef struct packed {
      logic wr_en;
      logic clear_all;
   } store_ctl_type;

endpackage

FILE: rtl/lmfb_store.sv
// Frame store: one row byte per (row, chip), synchronous (registered) read.
// Depends on lmfb_pkg (store_ctl_type).
`timescale 1ns / 1ps

module lmfb_store import lmfb_pkg::*; #(
   parameter int CHIPS = CHIPS_DEFAULT
) (
   input  logic                               clock,
   input  logic                               reset,
   input  store_ctl_type                      ctl,
   input  logic [$clog2(ROWS * CHIPS) - 1:0]  addr,
   input  logic [7:0]                         wr_data,
   output logic [7:0]                         rd_data
);

   localparam int DEPTH = ROWS * CHIPS;

   logic [7:0]       mem [DEPTH];
   logic [DEPTH-1:0] valid_ff;
   logic [7:0]       rd_data_ff;
   logic             rd_vld_ff;

   // Storage array, no reset: never-written entries are masked by valid bits
   always_ff @(posedge clock) begin
      if (ctl.wr_en) begin
         mem[addr] <= wr_data;
      end
      rd_data_ff <= mem[addr];
   end

   // Per-entry valid bits: cleared by reset and by clear-all
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff  <= '0;
         rd_vld_ff <= 1'b0;
      end else begin
         if (ctl.clear_all) begin
            valid_ff <= '0;
         end else if (ctl.wr_en) begin
            valid_ff[addr] <= 1'b1;
         end
         rd_vld_ff <= valid_ff[addr];
      end
   end

   // An entry not yet written reads as zero
   assign rd_data = rd_vld_ff ? rd_data_ff : 8'h00;

endmodule

FILE: rtl/led_matrix_frame_buffer_updater.sv
// Top level: request sequencer around the frame store, one result stage.
// Depends on lmfb_pkg and lmfb_store.
`timescale 1ns / 1ps

//  Channel   Ports                            Handshake
//  request   req_type req_x req_y req_value   start high while busy low
//  result    rsp_*                            rsp_valid for one cycle, no stall
//
//  Write/toggle: fetch, modify/write back, then one store read per chip;
//  columns beyond the chain emit nothing. Read: fetch, then the answer.
//  Clear all: clear, then one read per chip per row. The single store port serializes these steps.
//  Reset clears the store valid bits at once; no sweep after reset.
//  Results cannot be stalled; busy drops as the last result appears.

module led_matrix_frame_buffer_updater import lmfb_pkg::*; #(
   parameter int CHIPS = CHIPS_DEFAULT
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       start,
   output logic       busy,
   input  logic [1:0] req_type,
   input  logic [3:0] req_x,
   input  logic [2:0] req_y,
   input  logic       req_value,
   output logic       rsp_valid,
   output logic       rsp_is_read,
   output logic       rsp_pixel_value,
   output logic [3:0] rsp_digit_address,
   output logic [7:0] rsp_row_byte,
   output logic       rsp_latch_after,
   output logic       rsp_last
);

   localparam int DEPTH  = ROWS * CHIPS;
   localparam int IDX_W  = $clog2(DEPTH);
   localparam int CHIP_W = (CHIPS > 1) ? $clog2(CHIPS) : 1;

   seq_state_type    state_ff, state_in;
   req_op_type       op_ff;
   logic [2:0]       bit_ff;
   logic [2:0]       y_ff;
   logic             val_ff;
   logic             inside_ff;
   logic [IDX_W-1:0] idx_ff;
   logic [2:0]       row_ff, row_in;
   logic [CHIP_W-1:0] chip_ff, chip_in;
   logic             all_ff, all_in;

   // Result stage
   logic       out_valid_ff, out_valid_in;
   logic       out_read_ff, out_read_in;
   logic       out_inside_ff, out_inside_in;
   logic [2:0] out_bit_ff, out_bit_in;
   logic [3:0] out_addr_ff, out_addr_in;
   logic       out_latch_ff, out_latch_in;
   logic       out_last_ff, out_last_in;

   store_ctl_type    store_ctl;
   logic [IDX_W-1:0] store_addr;
   logic [7:0]       store_wdata;
   logic [7:0]       store_rdata;
   logic             accept;
   logic [7:0]       bit_mask;
   logic             last_chip;

   assign accept = start && !busy;
   assign busy   = (state_ff != ST_IDLE);

   lmfb_store #(.CHIPS(CHIPS)) u_store (
      .clock   (clock),
      .reset   (reset),
      .ctl     (store_ctl),
      .addr    (store_addr),
      .wr_data (store_wdata),
      .rd_data (store_rdata)
   );

   // Capture the transaction at acceptance
   always_ff @(posedge clock) begin
      if (accept) begin
         op_ff     <= req_op_type'(req_type);
         bit_ff    <= req_x[2:0];
         y_ff      <= req_y;
         val_ff    <= req_value;
         inside_ff <= (int'(req_x) < 8 * CHIPS);
         idx_ff    <= IDX_W'(int'(req_y) * CHIPS + int'(req_x[3]));
      end
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         row_ff       <= '0;
         chip_ff      <= '0;
         all_ff       <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         row_ff       <= row_in;
         chip_ff      <= chip_in;
         all_ff       <= all_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // Result payload
   always_ff @(posedge clock) begin
      out_read_ff   <= out_read_in;
      out_inside_ff <= out_inside_in;
      out_bit_ff    <= out_bit_in;
      out_addr_ff   <= out_addr_in;
      out_latch_ff  <= out_latch_in;
      out_last_ff   <= out_last_in;
   end

   // Bit mask, MSB-first within the chip byte
   assign bit_mask  = 8'h80 >> bit_ff;
   assign last_chip = (int'(chip_ff) == CHIPS - 1);

   // Sequencer: fetch, modify/write back, then one read per chip packet;
   // reads answer after the fetch, clear-all reads out every row. Write
   // back and the first packet read sit in different cycles, so no forwarding is needed.
   always_comb begin
      state_in      = state_ff;
      row_in        = row_ff;
      chip_in       = chip_ff;
      all_in        = all_ff;
      store_ctl     = '0;
      store_addr    = idx_ff;
      store_wdata   = store_rdata;
      out_valid_in  = 1'b0;
      out_read_in   = 1'b0;
      out_inside_in = inside_ff;
      out_bit_in    = bit_ff;
      out_addr_in   = 4'd0;
      out_latch_in  = 1'b0;
      out_last_in   = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               case (req_op_type'(req_type))
                  OP_CLEAR: state_in = ST_CLEAR;
                  OP_READ:  state_in = ST_FETCH;
                  default: begin
                     state_in = (int'(req_x) < 8 * CHIPS) ? ST_FETCH : ST_IDLE;
                  end
               endcase
            end
         end
         ST_FETCH: begin
            store_addr = idx_ff;
            if (op_ff == OP_READ) begin
               out_valid_in = 1'b1;
               out_read_in  = 1'b1;
               out_last_in  = 1'b1;
               state_in     = ST_IDLE;
            end else begin
               state_in = ST_MODIFY;
            end
         end
         ST_MODIFY: begin
            store_addr      = idx_ff;
            store_ctl.wr_en = 1'b1;
            if (op_ff == OP_TOGGLE) begin
               store_wdata = store_rdata ^ bit_mask;
            end else if (val_ff) begin
               store_wdata = store_rdata | bit_mask;
            end else begin
               store_wdata = store_rdata & ~bit_mask;
            end
            row_in   = y_ff;
            chip_in  = '0;
            all_in   = 1'b0;
            state_in = ST_EMIT;
         end
         ST_CLEAR: begin
            store_ctl.clear_all = 1'b1;
            row_in   = '0;
            chip_in  = '0;
            all_in   = 1'b1;
            state_in = ST_EMIT;
         end
         ST_EMIT: begin
            store_addr   = IDX_W'(int'(row_ff) * CHIPS + int'(chip_ff));
            out_valid_in = 1'b1;
            out_addr_in  = {1'b0, row_ff} + 4'd1;
            out_latch_in = last_chip;
            out_last_in  = last_chip && (!all_ff || (int'(row_ff) == LAST_ROW));
            if (last_chip) begin
               chip_in = '0;
               if (!all_ff || (int'(row_ff) == LAST_ROW)) begin
                  state_in = ST_IDLE;
               end else begin
                  row_in = row_ff + 3'd1;
               end
            end else begin
               chip_in = chip_ff + CHIP_W'(1);
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Result ports: store data arrives alongside the staged packet fields
   assign rsp_valid         = out_valid_ff;
   assign rsp_is_read       = out_read_ff;
   assign rsp_pixel_value   = out_read_ff && out_inside_ff && store_rdata[~out_bit_ff];
   assign rsp_digit_address = out_addr_ff;
   assign rsp_row_byte      = out_read_ff ? 8'h00 : store_rdata;
   assign rsp_latch_after   = out_latch_ff;
   assign rsp_last          = out_last_ff;

   // A read answer is always a single, final result
   a_read_is_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_is_read |-> rsp_last && !rsp_latch_after)
      else $error("read result not marked last");

   // A packet can only end the transaction when it closes a row
   a_last_on_latch: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_is_read && rsp_last |-> rsp_latch_after)
      else $error("last packet without latch mark");

   // Packets carry a nonzero digit address
   a_packet_addr: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_is_read |-> rsp_digit_address != 4'd0)
      else $error("packet with zero digit address");

   // A write back is always followed by packet emission
   a_modify_emit: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_MODIFY |=> state_ff == ST_EMIT)
      else $error("write back not followed by packets");

   // Every result must have been produced by fetch or emit in the previous cycle
   a_no_stray: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(state_ff) == ST_FETCH || $past(state_ff) == ST_EMIT)
      else $error("result without a source");

endmodule

FILE: tb/sv/lmfb_checker.sv
// Scoreboard for the LED matrix frame buffer updater: tracks the frame store,
// predicts the packets and read answers of each request and compares them.
// Depends on lmfb_pkg; instantiated by testbench beside the block.
`timescale 1ns / 1ps

module lmfb_checker import lmfb_pkg::*; #(
   parameter int CHIPS = CHIPS_DEFAULT
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       start,
   input  logic       busy,
   input  logic [1:0] req_type,
   input  logic [3:0] req_x,
   input  logic [2:0] req_y,
   input  logic       req_value,
   input  logic       rsp_valid,
   input  logic       rsp_is_read,
   input  logic       rsp_pixel_value,
   input  logic [3:0] rsp_digit_address,
   input  logic [7:0] rsp_row_byte,
   input  logic       rsp_latch_after,
   input  logic       rsp_last,
   output int         fail_count,
   output int         outstanding,
   output int         checked
);

   typedef struct packed {
      logic       is_read;
      logic       pixel_value;
      logic [3:0] digit_address;
      logic [7:0] row_byte;
      logic       latch_after;
      logic       last;
   } rsp_item_type;

   // Shadow of the frame store, one byte per row per chip
   logic [7:0] frame_bits [ROWS*CHIPS];
   // Packets and read answers not yet seen on the result port
   rsp_item_type expected_rsp [$];

   // Queue the packets of one row, chip 0 first, latch on the last chip
   task automatic queue_row_packets(input int row, input logic final_row);
      rsp_item_type item;
      for (int c = 0; c < CHIPS; c++) begin
         item.is_read       = 1'b0;
         item.pixel_value   = 1'b0;
         item.digit_address = 4'(row + 1);
         item.row_byte      = frame_bits[row*CHIPS + c];
         item.latch_after   = (c == CHIPS - 1);
         item.last          = (c == CHIPS - 1) && final_row;
         expected_rsp.push_back(item);
      end
   endtask

   // Update the shadow store for one request and queue what it causes
   task automatic apply_request(input req_op_type op, input logic [3:0] col,
                                input logic [2:0] row, input logic val);
      logic [7:0]   mask;
      logic         in_range;
      int           idx;
      rsp_item_type item;
      mask     = 8'h80 >> col[2:0];
      in_range = int'(col) < 8*CHIPS;
      idx      = int'(row)*CHIPS + int'(col >> 3);
      case (op)
         OP_CLEAR: begin
            for (int i = 0; i < ROWS*CHIPS; i++) frame_bits[i] = 8'h00;
            for (int r = 0; r < ROWS; r++) queue_row_packets(r, r == LAST_ROW);
         end
         OP_READ: begin
            item               = '0;
            item.is_read       = 1'b1;
            item.pixel_value   = in_range ? |(frame_bits[idx] & mask) : 1'b0;
            item.last          = 1'b1;
            expected_rsp.push_back(item);
         end
         default: begin
            // columns beyond the chain change nothing and emit nothing
            if (in_range) begin
               if (op == OP_TOGGLE)  frame_bits[idx] = frame_bits[idx] ^ mask;
               else if (val)         frame_bits[idx] = frame_bits[idx] | mask;
               else                  frame_bits[idx] = frame_bits[idx] & ~mask;
               queue_row_packets(int'(row), 1'b1);
            end
         end
      endcase
   endtask

   task automatic check_field(input string name, input int exp_val, input int act_val);
      if (exp_val != act_val) begin
         $display("%0t: mismatch in %s: expected %0d, actual %0d",
                  $time, name, exp_val, act_val);
         fail_count++;
      end
   endtask

   // Compare results first, then take in a new transaction: a result can
   // never belong to a request accepted at the same edge
   always @(posedge clock) begin
      rsp_item_type want;
      if (reset) begin
         for (int i = 0; i < ROWS*CHIPS; i++) frame_bits[i] = 8'h00;
         expected_rsp.delete();
      end else begin
         if (rsp_valid) begin
            if (expected_rsp.size() == 0) begin
               $display("%0t: unexpected result: expected none, actual addr %0d data %02h",
                        $time, rsp_digit_address, rsp_row_byte);
               fail_count++;
            end else begin
               want = expected_rsp.pop_front();
               check_field("is_read", want.is_read, rsp_is_read);
               check_field("pixel_value", want.pixel_value, rsp_pixel_value);
               check_field("digit_address", want.digit_address, rsp_digit_address);
               check_field("row_byte", want.row_byte, rsp_row_byte);
               check_field("latch_after", want.latch_after, rsp_latch_after);
               check_field("last", want.last, rsp_last);
               checked++;
            end
         end
         if (start && !busy)
            apply_request(req_op_type'(req_type), req_x, req_y, req_value);
      end
      outstanding = expected_rsp.size();
   end

   initial begin
      fail_count  = 0;
      outstanding = 0;
      checked     = 0;
   end

endmodule

FILE: tb/sv/testbench.sv
// Top of the LED matrix frame buffer updater testbench: clock, reset,
// request stimulus with random gaps, watchdog and verdict.
// Depends on lmfb_pkg, led_matrix_frame_buffer_updater and lmfb_checker.
`timescale 1ns / 1ps

module testbench import lmfb_pkg::*;;

   localparam int CHIPS        = CHIPS_DEFAULT;
   localparam int RANDOM_ITEMS = 450;
   localparam int IDLE_LIMIT   = 2000;
   localparam int DRAIN_CYCLES = 8*CHIPS + 4;

   logic       clock;
   logic       reset;
   logic       start;
   logic       busy;
   logic [1:0] req_type;
   logic [3:0] req_x;
   logic [2:0] req_y;
   logic       req_value;
   logic       rsp_valid;
   logic       rsp_is_read;
   logic       rsp_pixel_value;
   logic [3:0] rsp_digit_address;
   logic [7:0] rsp_row_byte;
   logic       rsp_latch_after;
   logic       rsp_last;

   int fail_count;
   int outstanding;
   int checked;
   int idle_cycles;
   int op_count [4];
   logic burst_mode;

   led_matrix_frame_buffer_updater #(.CHIPS(CHIPS)) uut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_type(req_type), .req_x(req_x), .req_y(req_y), .req_value(req_value),
      .rsp_valid(rsp_valid), .rsp_is_read(rsp_is_read),
      .rsp_pixel_value(rsp_pixel_value), .rsp_digit_address(rsp_digit_address),
      .rsp_row_byte(rsp_row_byte), .rsp_latch_after(rsp_latch_after),
      .rsp_last(rsp_last)
   );

   lmfb_checker #(.CHIPS(CHIPS)) scoreboard (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_type(req_type), .req_x(req_x), .req_y(req_y), .req_value(req_value),
      .rsp_valid(rsp_valid), .rsp_is_read(rsp_is_read),
      .rsp_pixel_value(rsp_pixel_value), .rsp_digit_address(rsp_digit_address),
      .rsp_row_byte(rsp_row_byte), .rsp_latch_after(rsp_latch_after),
      .rsp_last(rsp_last),
      .fail_count(fail_count), .outstanding(outstanding), .checked(checked)
   );

   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   // Watchdog: cycles without any accepted transaction or result
   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_valid) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("%0t: watchdog expired, %0d results outstanding", $time, outstanding);
         $display("[led_matrix_frame_buffer_updater] ERROR");
         $finish;
      end
   end

   // Present one request at a falling edge and hold it until accepted
   task automatic send_request(input req_op_type op, input logic [3:0] col,
                               input logic [2:0] row, input logic val);
      int gap;
      gap = burst_mode ? 0 : $urandom_range(0, 7);
      if (gap > 0) begin
         start = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_type  = op;
      req_x     = col;
      req_y     = row;
      req_value = val;
      start     = 1'b1;
      @(posedge clock);
      while (busy) @(posedge clock);
      op_count[op]++;
      @(negedge clock);
   endtask

   task automatic wait_all_results();
      start = 1'b0;
      while (outstanding != 0) @(negedge clock);
   endtask

   initial begin
      int pick;
      req_op_type op;
      clock       = 1'b0;
      reset       = 1'b1;
      start       = 1'b0;
      req_type    = OP_WRITE;
      req_x       = '0;
      req_y       = '0;
      req_value   = 1'b0;
      idle_cycles = 0;
      burst_mode  = 1'b0;
      foreach (op_count[i]) op_count[i] = 0;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Directed: corner pixels, MSB-first bit order, chip boundary,
      // toggle ignoring value, clear-all ignoring its fields
      send_request(OP_READ,   4'd0,  3'd0, 1'b1);
      send_request(OP_WRITE,  4'd0,  3'd0, 1'b1);
      send_request(OP_WRITE,  4'd15, 3'd7, 1'b1);
      send_request(OP_READ,   4'd0,  3'd0, 1'b0);
      send_request(OP_READ,   4'd15, 3'd7, 1'b0);
      send_request(OP_READ,   4'd1,  3'd0, 1'b0);
      send_request(OP_TOGGLE, 4'd7,  3'd3, 1'b1);
      send_request(OP_TOGGLE, 4'd8,  3'd3, 1'b0);
      send_request(OP_READ,   4'd7,  3'd3, 1'b0);
      send_request(OP_READ,   4'd8,  3'd3, 1'b1);
      send_request(OP_TOGGLE, 4'd7,  3'd3, 1'b0);
      send_request(OP_WRITE,  4'd15, 3'd7, 1'b0);
      send_request(OP_WRITE,  4'd9,  3'd4, 1'b1);
      send_request(OP_WRITE,  4'd9,  3'd4, 1'b1);
      send_request(OP_CLEAR,  4'd15, 3'd7, 1'b1);
      send_request(OP_READ,   4'd9,  3'd4, 1'b0);
      send_request(OP_WRITE,  4'd6,  3'd5, 1'b1);
      send_request(OP_CLEAR,  4'd0,  3'd0, 1'b0);
      send_request(OP_READ,   4'd6,  3'd5, 1'b1);

      // Random: mostly pixel updates and reads, occasional clears;
      // every 32 items alternate between gapped and back-to-back issue
      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         burst_mode = ((n / 32) % 2) == 1;
         if (n == RANDOM_ITEMS / 2) wait_all_results();
         pick = $urandom_range(0, 99);
         if (pick < 40)      op = OP_WRITE;
         else if (pick < 65) op = OP_TOGGLE;
         else if (pick < 95) op = OP_READ;
         else                op = OP_CLEAR;
         send_request(op, 4'($urandom_range(0, 15)), 3'($urandom_range(0, 7)),
                      1'($urandom_range(0, 1)));
      end

      wait_all_results();
      repeat (DRAIN_CYCLES) @(negedge clock);

      $display("Requests: %0d write, %0d toggle, %0d read, %0d clear-all",
               op_count[OP_WRITE], op_count[OP_TOGGLE], op_count[OP_READ],
               op_count[OP_CLEAR]);
      $display("Results compared: %0d, mismatches: %0d", checked, fail_count);
      if (fail_count == 0 && outstanding == 0) begin
         $display("[led_matrix_frame_buffer_updater] OK");
      end else begin
         $display("[led_matrix_frame_buffer_updater] ERROR");
      end
      $finish;
   end

endmodule
